/* rtl/fnp_pkg.sv */
// fnp_pkg: widths, condition codes, control word type and microprogram rom
`timescale 1ns / 1ps

package fnp_pkg;

    // payload widths
    localparam int COUNT_W = 7;
    localparam int PRIME_W = 9;
    localparam int POS_W   = 6;

    // default clip for requests
    localparam int MAX_COUNT_DEF = 64;

    // trial divisor never exceeds 18 for candidates up to 312
    localparam int DIV_W   = 5;
    localparam int SQ_W    = 2 * DIV_W;
    localparam int REM_W   = DIV_W + 1;

    // remainder unit: bits retired per step, steps per remainder
    localparam int DIV_BITS  = 3;
    localparam int DIV_STEPS = PRIME_W / DIV_BITS;

    // step counter
    localparam int PC_W = 4;

    // jump conditions
    localparam logic [2:0] C_ALWAYS   = 3'd0;
    localparam logic [2:0] C_IN_VALID = 3'd1;
    localparam logic [2:0] C_DONE     = 3'd2;
    localparam logic [2:0] C_SQ_GT    = 3'd3;
    localparam logic [2:0] C_REM_Z    = 3'd4;
    localparam logic [2:0] C_OUT_FREE = 3'd5;

    // step addresses
    localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] S_CAND  = 4'd1;
    localparam logic [PC_W-1:0] S_TEST  = 4'd2;
    localparam logic [PC_W-1:0] S_DIV0  = 4'd3;
    localparam logic [PC_W-1:0] S_DIV1  = 4'd4;
    localparam logic [PC_W-1:0] S_DIV2  = 4'd5;
    localparam logic [PC_W-1:0] S_CHECK = 4'd6;
    localparam logic [PC_W-1:0] S_EMIT  = 4'd7;
    localparam logic [PC_W-1:0] S_NEXT  = 4'd8;

    // datapath operations of one step
    typedef struct packed {
        logic in_rdy;
        logic init_d;
        logic ld_div;
        logic div_step;
        logic inc_d;
        logic emit;
        logic inc_cand;
    } t_ops;

    typedef struct packed {
        logic [2:0]      cond;
        logic [PC_W-1:0] tgt_t;
        logic [PC_W-1:0] tgt_f;
        t_ops            ops;
    } t_cw;

    // qualified strobes from sequencer to datapath
    typedef struct packed {
        logic ld_req;
        logic init_d;
        logic ld_div;
        logic div_step;
        logic inc_d;
        logic emit;
        logic inc_cand;
    } t_ctrl;

    // flags from datapath to sequencer
    typedef struct packed {
        logic done;
        logic sq_gt;
        logic rem_zero;
        logic out_free;
    } t_stat;

    localparam t_ops OPS_NONE = '{default: 1'b0};

    function automatic t_cw rom(input logic [PC_W-1:0] pc);
        t_cw w;
        w = '{cond: C_ALWAYS, tgt_t: S_IDLE, tgt_f: S_IDLE, ops: OPS_NONE};
        case (pc)
            S_IDLE: begin
                w.cond = C_IN_VALID; w.tgt_t = S_CAND; w.tgt_f = S_IDLE;
                w.ops.in_rdy = 1'b1;
            end
            S_CAND: begin
                w.cond = C_DONE; w.tgt_t = S_IDLE; w.tgt_f = S_TEST;
                w.ops.init_d = 1'b1;
            end
            S_TEST: begin
                w.cond = C_SQ_GT; w.tgt_t = S_EMIT; w.tgt_f = S_DIV0;
                w.ops.ld_div = 1'b1;
            end
            S_DIV0: begin
                w.cond = C_ALWAYS; w.tgt_t = S_DIV1; w.tgt_f = S_DIV1;
                w.ops.div_step = 1'b1;
            end
            S_DIV1: begin
                w.cond = C_ALWAYS; w.tgt_t = S_DIV2; w.tgt_f = S_DIV2;
                w.ops.div_step = 1'b1;
            end
            S_DIV2: begin
                w.cond = C_ALWAYS; w.tgt_t = S_CHECK; w.tgt_f = S_CHECK;
                w.ops.div_step = 1'b1;
            end
            S_CHECK: begin
                w.cond = C_REM_Z; w.tgt_t = S_NEXT; w.tgt_f = S_TEST;
                w.ops.inc_d = 1'b1;
            end
            S_EMIT: begin
                w.cond = C_OUT_FREE; w.tgt_t = S_NEXT; w.tgt_f = S_EMIT;
                w.ops.emit = 1'b1;
            end
            S_NEXT: begin
                w.cond = C_ALWAYS; w.tgt_t = S_CAND; w.tgt_f = S_CAND;
                w.ops.inc_cand = 1'b1;
            end
            default: begin
                w.cond = C_ALWAYS; w.tgt_t = S_IDLE; w.tgt_f = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/fnp_seq.sv */
// fnp_seq: step counter, microprogram fetch and conditional jumps
`timescale 1ns / 1ps

module fnp_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  fnp_pkg::t_stat       i_stat,
    output fnp_pkg::t_ctrl       o_ctrl,
    output logic                 o_in_rdy
);

    logic [fnp_pkg::PC_W-1:0] r_pc;
    logic [fnp_pkg::PC_W-1:0] n_pc;
    fnp_pkg::t_cw             cw;
    logic                     cond_ok;

    assign cw = fnp_pkg::rom(r_pc);

    always_comb begin
        case (cw.cond)
            fnp_pkg::C_ALWAYS:   cond_ok = 1'b1;
            fnp_pkg::C_IN_VALID: cond_ok = i_in_valid;
            fnp_pkg::C_DONE:     cond_ok = i_stat.done;
            fnp_pkg::C_SQ_GT:    cond_ok = i_stat.sq_gt;
            fnp_pkg::C_REM_Z:    cond_ok = i_stat.rem_zero;
            fnp_pkg::C_OUT_FREE: cond_ok = i_stat.out_free;
            default:             cond_ok = 1'b1;
        endcase
        n_pc = cond_ok ? cw.tgt_t : cw.tgt_f;
    end

    // handshake-dependent ops only fire when their beat happens
    always_comb begin
        o_ctrl.ld_req   = cw.ops.in_rdy & i_in_valid;
        o_ctrl.init_d   = cw.ops.init_d;
        o_ctrl.ld_div   = cw.ops.ld_div;
        o_ctrl.div_step = cw.ops.div_step;
        o_ctrl.inc_d    = cw.ops.inc_d;
        o_ctrl.emit     = cw.ops.emit & i_stat.out_free;
        o_ctrl.inc_cand = cw.ops.inc_cand;
    end

    assign o_in_rdy = cw.ops.in_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= fnp_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

/* rtl/fnp_dpath.sv */
// fnp_dpath: candidate, divisor, remainder unit, counters and output register
`timescale 1ns / 1ps

module fnp_dpath #(
    parameter int MAX_COUNT = fnp_pkg::MAX_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fnp_pkg::t_ctrl                i_ctrl,
    input  logic [fnp_pkg::COUNT_W-1:0]   i_count,
    input  logic                          i_out_stall,
    output fnp_pkg::t_stat                o_stat,
    output logic                          o_out_valid,
    output logic [fnp_pkg::PRIME_W-1:0]   o_prime,
    output logic [fnp_pkg::POS_W-1:0]     o_position,
    output logic                          o_last
);

    localparam logic [fnp_pkg::COUNT_W-1:0] MAX_C = fnp_pkg::COUNT_W'(MAX_COUNT);

    logic [fnp_pkg::COUNT_W-1:0] r_want;
    logic [fnp_pkg::COUNT_W-1:0] r_found;
    logic [fnp_pkg::PRIME_W-1:0] r_cand;
    logic [fnp_pkg::DIV_W-1:0]   r_d;
    logic [fnp_pkg::PRIME_W-1:0] r_dsh;
    logic [fnp_pkg::REM_W-1:0]   r_rem;
    logic                        r_out_valid;
    logic [fnp_pkg::PRIME_W-1:0] r_prime;
    logic [fnp_pkg::POS_W-1:0]   r_position;
    logic                        r_last;

    logic [fnp_pkg::REM_W-1:0]   n_rem;
    logic [fnp_pkg::PRIME_W-1:0] n_dsh;
    logic [fnp_pkg::SQ_W-1:0]    d_sq;
    logic [fnp_pkg::COUNT_W-1:0] found_p1;
    logic                        out_free;

    // restoring remainder, a few dividend bits per step
    always_comb begin
        logic [fnp_pkg::REM_W-1:0] t;
        t = r_rem;
        for (int k = 0; k < fnp_pkg::DIV_BITS; k++) begin
            t = {t[fnp_pkg::REM_W-2:0], r_dsh[fnp_pkg::PRIME_W-1-k]};
            if (t >= {1'b0, r_d}) begin
                t = t - {1'b0, r_d};
            end
        end
        n_rem = t;
        n_dsh = r_dsh << fnp_pkg::DIV_BITS;
    end

    assign d_sq     = fnp_pkg::SQ_W'(r_d) * fnp_pkg::SQ_W'(r_d);
    assign found_p1 = r_found + 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_stat.done     = (r_found == r_want);
    assign o_stat.sq_gt    = (d_sq > {1'b0, r_cand});
    assign o_stat.rem_zero = (r_rem == '0);
    assign o_stat.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_req) begin
            r_want  <= (i_count > MAX_C) ? MAX_C : i_count;
            r_found <= '0;
            r_cand  <= fnp_pkg::PRIME_W'(2);
        end else begin
            if (i_ctrl.emit) begin
                r_found <= found_p1;
            end
            if (i_ctrl.inc_cand) begin
                r_cand <= r_cand + 1'b1;
            end
        end
        if (i_ctrl.init_d) begin
            r_d <= fnp_pkg::DIV_W'(2);
        end else if (i_ctrl.inc_d) begin
            r_d <= r_d + 1'b1;
        end
        if (i_ctrl.ld_div) begin
            r_dsh <= r_cand;
            r_rem <= '0;
        end else if (i_ctrl.div_step) begin
            r_dsh <= n_dsh;
            r_rem <= n_rem;
        end
        if (i_ctrl.emit) begin
            r_prime    <= r_cand;
            r_position <= r_found[fnp_pkg::POS_W-1:0];
            r_last     <= (found_p1 == r_want);
        end
    end

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_prime     = r_prime;
    assign o_position  = r_position;
    assign o_last      = r_last;

endmodule

/* rtl/first_n_primes_trial_division.sv */
// first_n_primes_trial_division: top level, microcoded trial-division prime generator
`timescale 1ns / 1ps

// channel  | handshake               | payload
// ---------+-------------------------+----------------------------------
// request  | i_in_valid / o_in_stall | i_count (7b)
// result   | o_out_valid / i_out_stall | o_prime (9b), o_position (6b), o_last
//
// one request beat yields min(count, MAX_COUNT) result beats, none for a zero count
// each trial remainder passes through five steps of the microprogram (square test,
// three remainder steps of three bits each, zero check)
// a new request is taken only once the previous run has emitted its last prime
// synchronous active-low reset returns the step counter to idle and drops o_out_valid
// a stalled result holds the output register; the program waits in its emit step

module first_n_primes_trial_division #(
    parameter int MAX_COUNT = fnp_pkg::MAX_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    input  logic [fnp_pkg::COUNT_W-1:0]   i_count,
    output logic                          o_in_stall,
    // result channel
    output logic                          o_out_valid,
    output logic [fnp_pkg::PRIME_W-1:0]   o_prime,
    output logic [fnp_pkg::POS_W-1:0]     o_position,
    output logic                          o_last,
    input  logic                          i_out_stall
);

    fnp_pkg::t_ctrl ctrl;
    fnp_pkg::t_stat stat;
    logic           in_rdy;

    // sequencer: step counter plus rom, only the idle step takes a request
    fnp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_in_rdy   (in_rdy)
    );

    assign o_in_stall = !in_rdy;

    // datapath: candidate/divisor registers, remainder unit, output register
    fnp_dpath #(
        .MAX_COUNT (MAX_COUNT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_count     (i_count),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_prime     (o_prime),
        .o_position  (o_position),
        .o_last      (o_last)
    );

endmodule
